FILE: src/bfha_pkg.sv
// shared constants for the best-fit heap allocator
`default_nettype none
package bfha_pkg;
   localparam int unsigned POOL_DEPTH_DEF = 4096;
   localparam int unsigned MAX_FREE_DEF = 64;
   localparam int unsigned ELEM_BYTES = 16;
   localparam int unsigned POOL_RESET_MAX = 4096;
   localparam int unsigned SPLIT_MIN = 2;

   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_RSVD = 2'd3;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_BAD = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   localparam logic REG_POOL = 1'b0;

   typedef logic [1:0] status_type;
endpackage
`default_nettype wire

FILE: src/best_fit_heap_allocator_top.sv
// best-fit heap allocator with address-ordered free table and coalescing
// one beat at a time: a new beat is taken only once the previous one, with its sequential
// scans over the free-extent table, has finished and its result has been handed on
// reset and every pool_elements write start a clearing pass over the block header
// memory, during which no beat is accepted
`default_nettype none
module best_fit_heap_allocator_top #(
   parameter int unsigned POOL_DEPTH = bfha_pkg::POOL_DEPTH_DEF,
   parameter int unsigned MAX_FREE_EXTENTS = bfha_pkg::MAX_FREE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // request_size, block_address
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_address, status, stored_size
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bfha_pkg::*;

   localparam int EW = $clog2(POOL_DEPTH);
   localparam int PW = $clog2(POOL_DEPTH + 1);
   localparam int FW = $clog2(MAX_FREE_EXTENTS);
   localparam int CW = $clog2(MAX_FREE_EXTENTS + 1);
   localparam int BW = 1 + EW + 16;
   localparam int unsigned POOL_RST = (POOL_DEPTH < POOL_RESET_MAX) ? POOL_DEPTH
                                                                    : POOL_RESET_MAX;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CLR = 4'd1;
   localparam logic [3:0] ST_CHK = 4'd2;
   localparam logic [3:0] ST_ASCAN = 4'd3;
   localparam logic [3:0] ST_FSCAN = 4'd4;
   localparam logic [3:0] ST_FDEC = 4'd5;
   localparam logic [3:0] ST_SHDN = 4'd6;
   localparam logic [3:0] ST_SHUP = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [PW-1:0] pool_ff, pool_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [EW-1:0] clr_ff, clr_in;
   logic [1:0] kind_ff, kind_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] addr_ff, addr_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] left_ff, left_in;
   logic dv_ff, dv_in;
   logic [CW-1:0] di_ff, di_in;
   logic found_ff, found_in;
   logic [CW-1:0] bidx_ff, bidx_in;
   logic [EW-1:0] bstart_ff, bstart_in;
   logic [EW-1:0] blen_ff, blen_in;
   logic [EW-1:0] flen_ff, flen_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [2*EW-1:0] prev_ff, prev_in;
   logic [2*EW-1:0] next_ff, next_in;
   logic hasnext_ff, hasnext_in;
   logic [15:0] ra_ff, ra_in;
   status_type st_ff, st_in;
   logic [15:0] sz_ff, sz_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic [2*EW-1:0] ft_mem [MAX_FREE_EXTENTS];
   logic [2*EW-1:0] ft_q_ff;
   logic ft_we;
   logic [FW-1:0] ft_wa, ft_ra;
   logic [2*EW-1:0] ft_wd;

   logic [BW-1:0] blk_mem [POOL_DEPTH];
   logic [BW-1:0] blk_q_ff;
   logic blk_we;
   logic [EW-1:0] blk_wa, blk_ra;
   logic [BW-1:0] blk_wd;

   logic [16:0] in_hdr_w, hdr_w;
   logic [EW-1:0] hdr_idx;
   logic addr_ok;
   logic [12:0] need;
   logic [EW-1:0] q_start, q_len;
   logic [EW-1:0] prev_start, prev_len, next_start, next_len;
   logic join_prev, join_next;
   logic cfg_wr;
   logic [31:0] cfg_val;

   always_ff @(posedge clock) begin
      if (ft_we) begin
         ft_mem[ft_wa] <= ft_wd;
      end
      ft_q_ff <= ft_mem[ft_ra];
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_wa] <= blk_wd;
      end
      blk_q_ff <= blk_mem[blk_ra];
   end

   assign in_hdr_w = 17'(req_tdata[31:20]) - 17'd1;
   assign hdr_w = 17'(addr_ff[15:4]) - 17'd1;
   assign hdr_idx = hdr_w[EW-1:0];
   assign addr_ok = (addr_ff[3:0] == 4'd0) && (addr_ff[15:4] != 12'd0) &&
                    (17'(addr_ff[15:4]) <= 17'(pool_ff));
   assign need = 13'((17'(size_ff) + 17'd15) >> 4);
   assign q_start = ft_q_ff[2*EW-1:EW];
   assign q_len = ft_q_ff[EW-1:0];
   assign prev_start = prev_ff[2*EW-1:EW];
   assign prev_len = prev_ff[EW-1:0];
   assign next_start = next_ff[2*EW-1:EW];
   assign next_len = next_ff[EW-1:0];
   assign join_prev = (pos_ff != '0) &&
                      (17'(prev_start) + 17'd1 + 17'(prev_len) == hdr_w);
   assign join_next = hasnext_ff && (hdr_w + 17'd1 + 17'(flen_ff) == 17'(next_start));

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_POOL);
   assign cfg_val = csr_pwdata;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POOL) ? 32'(pool_ff) : 32'd0;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      pool_in = pool_ff;
      cnt_in = cnt_ff;
      clr_in = clr_ff;
      kind_in = kind_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      rd_in = rd_ff;
      left_in = left_ff;
      dv_in = 1'b0;
      di_in = di_ff;
      found_in = found_ff;
      bidx_in = bidx_ff;
      bstart_in = bstart_ff;
      blen_in = blen_ff;
      flen_in = flen_ff;
      pos_in = pos_ff;
      prev_in = prev_ff;
      next_in = next_ff;
      hasnext_in = hasnext_ff;
      ra_in = ra_ff;
      st_in = st_ff;
      sz_in = sz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      ft_we = 1'b0;
      ft_wa = '0;
      ft_wd = '0;
      ft_ra = rd_ff[FW-1:0];
      blk_we = 1'b0;
      blk_wa = hdr_idx;
      blk_wd = '0;
      blk_ra = (state_ff == ST_IDLE) ? in_hdr_w[EW-1:0] : hdr_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               size_in = req_tdata[15:0];
               addr_in = req_tdata[31:16];
               ra_in = '0;
               st_in = STAT_OK;
               sz_in = '0;
               rd_in = '0;
               found_in = 1'b0;
               hasnext_in = 1'b0;
               pos_in = '0;
               if (req_tuser == KIND_ALLOC) begin
                  state_in = ST_ASCAN;
               end else if (req_tuser == KIND_FREE || req_tuser == KIND_QUERY) begin
                  state_in = ST_CHK;
               end else begin
                  st_in = STAT_BAD;
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLR: begin
            blk_we = 1'b1;
            blk_wa = clr_ff;
            blk_wd = '0;
            ft_we = 1'b1;
            ft_wa = '0;
            ft_wd = {EW'(0), EW'(pool_ff - PW'(1))};
            cnt_in = CW'(1);
            if (clr_ff == EW'(POOL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + EW'(1);
            end
         end
         ST_CHK: begin
            if (!addr_ok || !blk_q_ff[BW-1]) begin
               st_in = STAT_BAD;
               state_in = ST_DONE;
            end else if (kind_ff == KIND_QUERY) begin
               sz_in = blk_q_ff[15:0];
               state_in = ST_DONE;
            end else begin
               flen_in = blk_q_ff[BW-2:16];
               state_in = ST_FSCAN;
            end
         end
         ST_ASCAN: begin
            if (rd_ff < cnt_ff) begin
               dv_in = 1'b1;
               di_in = rd_ff;
               rd_in = rd_ff + CW'(1);
            end
            if (dv_ff && (32'(q_len) >= 32'(need)) && (!found_ff || q_len < blen_ff)) begin
               found_in = 1'b1;
               bidx_in = di_ff;
               bstart_in = q_start;
               blen_in = q_len;
            end
            if (rd_ff == cnt_ff && !dv_ff) begin
               if (!found_ff) begin
                  st_in = STAT_NOFIT;
                  state_in = ST_DONE;
               end else begin
                  ra_in = 16'((32'(bstart_ff) + 32'd1) * ELEM_BYTES);
                  blk_we = 1'b1;
                  blk_wa = bstart_ff;
                  if (32'(blen_ff) > 32'(need) + SPLIT_MIN) begin
                     blk_wd = {1'b1, EW'(need), size_ff};
                     ft_we = 1'b1;
                     ft_wa = bidx_ff[FW-1:0];
                     ft_wd = {EW'(32'(bstart_ff) + 32'd1 + 32'(need)),
                              EW'(32'(blen_ff) - 32'(need) - 32'd1)};
                     state_in = ST_DONE;
                  end else begin
                     blk_wd = {1'b1, blen_ff, size_ff};
                     rd_in = bidx_ff + CW'(1);
                     left_in = cnt_ff - CW'(1) - bidx_ff;
                     state_in = ST_SHDN;
                  end
               end
            end
         end
         ST_FSCAN: begin
            if (rd_ff < cnt_ff) begin
               dv_in = 1'b1;
               di_in = rd_ff;
               rd_in = rd_ff + CW'(1);
            end
            if (dv_ff && !hasnext_ff) begin
               if (17'(q_start) < hdr_w) begin
                  prev_in = ft_q_ff;
                  pos_in = di_ff + CW'(1);
               end else begin
                  hasnext_in = 1'b1;
                  next_in = ft_q_ff;
               end
            end
            if (rd_ff == cnt_ff && !dv_ff) begin
               state_in = ST_FDEC;
            end
         end
         ST_FDEC: begin
            if (!join_prev && !join_next && cnt_ff >= CW'(MAX_FREE_EXTENTS)) begin
               st_in = STAT_FULL;
               state_in = ST_DONE;
            end else begin
               blk_we = 1'b1;
               blk_wa = hdr_idx;
               blk_wd = {1'b0, flen_ff, 16'd0};
               if (join_prev && join_next) begin
                  ft_we = 1'b1;
                  ft_wa = FW'(pos_ff - CW'(1));
                  ft_wd = {prev_start, prev_len + flen_ff + next_len + EW'(2)};
                  rd_in = pos_ff + CW'(1);
                  left_in = cnt_ff - CW'(1) - pos_ff;
                  state_in = ST_SHDN;
               end else if (join_prev) begin
                  ft_we = 1'b1;
                  ft_wa = FW'(pos_ff - CW'(1));
                  ft_wd = {prev_start, prev_len + flen_ff + EW'(1)};
                  state_in = ST_DONE;
               end else if (join_next) begin
                  ft_we = 1'b1;
                  ft_wa = pos_ff[FW-1:0];
                  ft_wd = {hdr_idx, next_len + flen_ff + EW'(1)};
                  state_in = ST_DONE;
               end else begin
                  rd_in = cnt_ff - CW'(1);
                  left_in = cnt_ff - pos_ff;
                  state_in = ST_SHUP;
               end
            end
         end
         ST_SHDN: begin
            if (left_ff != '0) begin
               dv_in = 1'b1;
               di_in = rd_ff;
               rd_in = rd_ff + CW'(1);
               left_in = left_ff - CW'(1);
            end
            if (dv_ff) begin
               ft_we = 1'b1;
               ft_wa = FW'(di_ff - CW'(1));
               ft_wd = ft_q_ff;
            end
            if (left_ff == '0 && !dv_ff) begin
               cnt_in = cnt_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_SHUP: begin
            if (left_ff != '0) begin
               dv_in = 1'b1;
               di_in = rd_ff;
               rd_in = rd_ff - CW'(1);
               left_in = left_ff - CW'(1);
            end
            if (dv_ff) begin
               ft_we = 1'b1;
               ft_wa = FW'(di_ff + CW'(1));
               ft_wd = ft_q_ff;
            end
            if (left_ff == '0 && !dv_ff) begin
               ft_we = 1'b1;
               ft_wa = pos_ff[FW-1:0];
               ft_wd = {hdr_idx, flen_ff};
               cnt_in = cnt_ff + CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'd0, sz_ff, st_ff, ra_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         if (cfg_val < 32'd2) begin
            pool_in = PW'(2);
         end else if (cfg_val > 32'(POOL_DEPTH)) begin
            pool_in = PW'(POOL_DEPTH);
         end else begin
            pool_in = PW'(cfg_val);
         end
         clr_in = '0;
         state_in = ST_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         pool_ff <= PW'(POOL_RST);
         clr_ff <= '0;
         cnt_ff <= CW'(1);
         dv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
         dv_ff <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      rd_ff <= rd_in;
      left_ff <= left_in;
      di_ff <= di_in;
      found_ff <= found_in;
      bidx_ff <= bidx_in;
      bstart_ff <= bstart_in;
      blen_ff <= blen_in;
      flen_ff <= flen_in;
      pos_ff <= pos_in;
      prev_ff <= prev_in;
      next_ff <= next_in;
      hasnext_ff <= hasnext_in;
      ra_ff <= ra_in;
      st_ff <= st_in;
      sz_ff <= sz_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

FILE: src/bfha_checker.sv
// port-level checks for the best-fit heap allocator
`default_nettype none
module bfha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import bfha_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != STAT_OK |-> rsp_tdata[15:0] == 16'd0
                                                  && rsp_tdata[33:18] == 16'd0)
      else $error("failed beat carries nonzero fields");

   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] == 4'd0)
      else $error("result address not element aligned");

   a_addr_or_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == 16'd0 || rsp_tdata[33:18] == 16'd0)
      else $error("beat carries both address and stored size");
endmodule

bind best_fit_heap_allocator_top bfha_checker u_bfha_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: tb/best_fit_heap_allocator_top_test.sv
// self-checking testbench for the best-fit heap allocator: predicted results per beat
`default_nettype none
module best_fit_heap_allocator_top_test;
   import bfha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 4096;
   localparam int NFREE = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] size;
      logic [15:0] addr;
   } heap_req_type;

   typedef struct {
      logic [15:0] address;
      status_type  status;
      logic [15:0] bytes;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // request_size, block_address
   logic [1:0]  req_tuser = '0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // result_address, status, stored_size
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   best_fit_heap_allocator_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // allocator shadow state
   int unsigned pool_n;
   int unsigned ext_start[NFREE];
   int unsigned ext_len[NFREE];
   int unsigned ext_cnt;
   bit          hdr_live[DEPTH];
   int unsigned hdr_elems[DEPTH];
   int unsigned hdr_bytes[DEPTH];

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   heap_req_type cur_req;
   int        errors = 0;
   bit        calm = 1'b0;
   int        stall_cycles = 0;

   function automatic void clear_pool(int unsigned n);
      pool_n = n < 2 ? 2 : (n > DEPTH ? DEPTH : n);
      for (int i = 0; i < NFREE; i++) begin
         ext_start[i] = 0;
         ext_len[i] = 0;
      end
      for (int i = 0; i < DEPTH; i++) hdr_live[i] = 1'b0;
      ext_len[0] = pool_n - 1;
      ext_cnt = 1;
   endfunction

   function automatic bit live_hdr(int unsigned addr, output int unsigned hdr);
      int unsigned elem;
      hdr = 0;
      if (addr % ELEM_BYTES != 0) return 1'b0;
      elem = addr / ELEM_BYTES;
      if (elem == 0 || elem > pool_n) return 1'b0;
      hdr = elem - 1;
      return hdr_live[hdr];
   endfunction

   function automatic bit merge_extent(int unsigned hdr, int unsigned len);
      int unsigned pos = 0;
      bit jp = 1'b0, jn = 1'b0;
      while (pos < ext_cnt && ext_start[pos] < hdr) pos++;
      if (pos > 0 && ext_start[pos-1] + 1 + ext_len[pos-1] == hdr) jp = 1'b1;
      if (pos < ext_cnt && hdr + 1 + len == ext_start[pos]) jn = 1'b1;
      if (jp && jn) begin
         ext_len[pos-1] += len + 1 + ext_len[pos] + 1;
         for (int unsigned k = pos; k + 1 < ext_cnt; k++) begin
            ext_start[k] = ext_start[k+1];
            ext_len[k] = ext_len[k+1];
         end
         ext_cnt--;
      end else if (jp) begin
         ext_len[pos-1] += len + 1;
      end else if (jn) begin
         ext_start[pos] = hdr;
         ext_len[pos] += len + 1;
      end else begin
         if (ext_cnt >= NFREE) return 1'b0;
         for (int unsigned k = ext_cnt; k > pos; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_len[k] = ext_len[k-1];
         end
         ext_start[pos] = hdr;
         ext_len[pos] = len;
         ext_cnt++;
      end
      return 1'b1;
   endfunction

   function automatic void predict_rsp(heap_req_type r);
      heap_rsp_type e;
      int unsigned need, best, len, hdr;
      bit found;
      e.address = '0;
      e.status = STAT_OK;
      e.bytes = '0;
      if (r.kind == KIND_ALLOC) begin
         need = (int'(r.size) + ELEM_BYTES - 1) / ELEM_BYTES;
         found = 1'b0;
         best = 0;
         for (int unsigned i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= need && (!found || ext_len[i] < ext_len[best])) begin
               best = i;
               found = 1'b1;
            end
         if (!found) begin
            e.status = STAT_NOFIT;
         end else begin
            len = ext_len[best];
            hdr = ext_start[best];
            if (len - need > SPLIT_MIN) begin
               ext_start[best] = hdr + 1 + need;
               ext_len[best] = len - need - 1;
               hdr_elems[hdr] = need;
            end else begin
               for (int unsigned i = best; i + 1 < ext_cnt; i++) begin
                  ext_start[i] = ext_start[i+1];
                  ext_len[i] = ext_len[i+1];
               end
               ext_cnt--;
               hdr_elems[hdr] = len;
            end
            hdr_live[hdr] = 1'b1;
            hdr_bytes[hdr] = r.size;
            e.address = 16'((hdr + 1) * ELEM_BYTES);
         end
      end else if (r.kind == KIND_FREE) begin
         if (!live_hdr(r.addr, hdr)) e.status = STAT_BAD;
         else if (!merge_extent(hdr, hdr_elems[hdr])) e.status = STAT_FULL;
         else hdr_live[hdr] = 1'b0;
      end else if (r.kind == KIND_QUERY) begin
         if (!live_hdr(r.addr, hdr)) e.status = STAT_BAD;
         else e.bytes = 16'(hdr_bytes[hdr]);
      end else begin
         e.status = STAT_BAD;
      end
      expected_rsps.push_back(e);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_rsp(cur_req);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
               cur_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_req.addr, cur_req.size};
               req_tuser <= cur_req.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      heap_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_tdata[15:0] !== e.address) begin
                  $error("result_address: expected %0d actual %0d", e.address, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[17:16] !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_tdata[17:16]);
                  errors++;
               end
               if (rsp_tdata[33:18] !== e.bytes) begin
                  $error("stored_size: expected %0d actual %0d", e.bytes, rsp_tdata[33:18]);
                  errors++;
               end
            end
         end
         rsp_tready <= calm || $urandom_range(0, 99) >= 32;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("best_fit_heap_allocator_top_test: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0);
   endtask

   task automatic write_pool(int unsigned v);
      repeat (8) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_POOL, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      clear_pool(v);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic push_req(logic [1:0] k, logic [15:0] s, logic [15:0] a);
      heap_req_type r;
      r.kind = k;
      r.size = s;
      r.addr = a;
      pending_reqs.push_back(r);
   endtask

   task automatic live_addrs(ref logic [15:0] list[$]);
      list.delete();
      for (int i = 0; i < DEPTH; i++)
         if (hdr_live[i]) list.push_back(16'((i + 1) * ELEM_BYTES));
   endtask

   task automatic random_batch(int n);
      logic [15:0] live[$];
      logic [15:0] sz, ad;
      int p, j;
      live_addrs(live);
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         j = $urandom_range(0, 99);
         sz = j < 70 ? 16'($urandom_range(0, 64)) :
              j < 92 ? 16'($urandom_range(0, 1024)) : 16'($urandom());
         ad = 16'($urandom());
         if (p >= 50 && p < 95 && live.size() > 0 && $urandom_range(0, 99) < 85) begin
            j = $urandom_range(0, live.size() - 1);
            ad = live[j];
            if (p < 80) live.delete(j);
         end
         if (p < 50) push_req(KIND_ALLOC, sz, ad);
         else if (p < 80) push_req(KIND_FREE, sz, ad);
         else if (p < 95) push_req(KIND_QUERY, sz, ad);
         else push_req(KIND_RSVD, sz, ad);
      end
      drain();
   endtask

   task automatic fragment_pool(int n);
      logic [15:0] live[$];
      for (int i = 0; i < n; i++) push_req(KIND_ALLOC, 16'($urandom_range(1, 16)), '0);
      drain();
      live_addrs(live);
      for (int i = 0; i < live.size(); i += 2) push_req(KIND_FREE, '0, live[i]);
      drain();
   endtask

   initial begin
      int unsigned pools[7] = '{0, 1, 3, 70000, 100, 8191, 4096};
      clear_pool(POOL_RESET_MAX);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      push_req(KIND_ALLOC, 16'd0, '0);
      push_req(KIND_ALLOC, 16'd1, '0);
      push_req(KIND_ALLOC, 16'd32, '0);
      push_req(KIND_QUERY, '0, 16'd16);
      push_req(KIND_QUERY, '0, 16'd32);
      push_req(KIND_QUERY, '0, 16'd48);
      push_req(KIND_FREE, '0, 16'd32);
      push_req(KIND_FREE, '0, 16'd48);
      push_req(KIND_FREE, '0, 16'd16);
      push_req(KIND_FREE, '0, 16'd8);
      push_req(KIND_FREE, '0, 16'd0);
      push_req(KIND_FREE, '0, 16'hFFF0);
      push_req(KIND_QUERY, '0, 16'd32);
      push_req(KIND_RSVD, 16'hFFFF, 16'hFFFF);
      push_req(KIND_ALLOC, 16'hFFFF, '0);
      push_req(KIND_ALLOC, 16'hFFF0, '0);
      push_req(KIND_QUERY, 16'hFFFF, 16'd16);
      push_req(KIND_FREE, '0, 16'd16);
      drain();

      fragment_pool(150);
      random_batch(60);

      foreach (pools[i]) begin
         write_pool(pools[i]);
         calm = (i == 4);
         if (pools[i] == DEPTH) fragment_pool(140);
         for (int b = 0; b < 2; b++) random_batch(20);
      end
      write_pool($urandom_range(2, 4096));
      for (int b = 0; b < 2; b++) random_batch(20);

      repeat (300) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("best_fit_heap_allocator_top_test: PASS");
      end else begin
         $display("best_fit_heap_allocator_top_test: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
